### sv/tbp_pkg.sv
`timescale 1ns / 1ps
// Package for the tournament branch predictor: request types, table defaults,
// counter constants and the controller/datapath command and status structs. No dependencies.
package tbp_pkg;

    localparam int ADDR_W            = 32;
    localparam int CNT_W             = 32;
    localparam int HIST_W            = 11;
    localparam int HB_W              = 4;
    localparam int CTR_W             = 2;
    localparam int TABLE_ENTRIES_DEF = 2048;

    localparam logic [CTR_W-1:0] CTR_MAX     = 2'd3;
    localparam logic [CTR_W-1:0] CTR_MIN     = 2'd0;
    localparam logic [CTR_W-1:0] GSH_RESET   = 2'd3;
    localparam logic [CTR_W-1:0] BIM_RESET   = 2'd3;
    localparam logic [CTR_W-1:0] CHO_RESET   = 2'd0;
    localparam logic [HB_W-1:0]  HB_RESET    = 4'd11;

    typedef struct packed {
        logic [ADDR_W-1:0] branch_address;
        logic              taken;
    } t_in_item;

    typedef struct packed {
        logic             predicted_taken;
        logic             prediction_correct;
        logic             used_bimodal;
        logic [CNT_W-1:0] correct_total;
        logic [CNT_W-1:0] branch_total;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic clr_we;
        logic div_step;
        logic rd_en;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic clr_last;
        logic need_div;
        logic div_last;
        logic out_free;
    } t_ctl_sts;

    function automatic logic [CTR_W-1:0] ctr_step(input logic [CTR_W-1:0] c,
                                                  input logic up);
        logic [CTR_W-1:0] r;
        if (up) begin
            r = (c == CTR_MAX) ? CTR_MAX : c + 1'b1;
        end else begin
            r = (c == CTR_MIN) ? CTR_MIN : c - 1'b1;
        end
        return r;
    endfunction

endpackage

### sv/tbp_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the tournament branch predictor: table clear, index reduction,
// table read and commit. Depends on tbp_pkg.
module tbp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tbp_pkg::t_ctl_sts i_sts,
    output tbp_pkg::t_ctl_cmd o_cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_READ   = 5'b01000,
        ST_COMMIT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_sts.need_div ? ST_DIV : ST_READ;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

### sv/tbp_datapath.sv
`timescale 1ns / 1ps
// Datapath of the tournament branch predictor: counter tables, history, index
// reduction, prediction, counts and result register. Depends on tbp_pkg.
module tbp_datapath #(
    parameter int TABLE_ENTRIES = tbp_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tbp_pkg::t_in_item              i_in_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tbp_pkg::HB_W-1:0]       i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tbp_pkg::t_out_item             o_out_data,
    input  tbp_pkg::t_ctl_cmd              i_cmd,
    output tbp_pkg::t_ctl_sts              o_sts
);

    localparam int IDX_W     = $clog2(TABLE_ENTRIES);
    localparam int DCNT_W    = 2;
    localparam int DIV_STEPS = 3;
    localparam bit NEED_DIV  = (TABLE_ENTRIES != (1 << IDX_W));
    localparam int AW        = tbp_pkg::ADDR_W;
    localparam int HW        = tbp_pkg::HIST_W;
    localparam int CW        = tbp_pkg::CTR_W;

    localparam logic [AW-1:0]  RECIP = AW'((64'd1 << AW) / 64'(TABLE_ENTRIES));
    localparam logic [IDX_W:0] ENT_X = (IDX_W+1)'(TABLE_ENTRIES);

    logic [CW-1:0] gsh_mem [TABLE_ENTRIES];
    logic [CW-1:0] bim_mem [TABLE_ENTRIES];
    logic [CW-1:0] cho_mem [TABLE_ENTRIES];

    logic [tbp_pkg::HB_W-1:0]  r_hist_bits;
    logic [HW-1:0]             r_hist;
    logic [tbp_pkg::CNT_W-1:0] r_correct;
    logic [tbp_pkg::CNT_W-1:0] r_branch;
    logic [IDX_W-1:0]          r_clr_idx;
    logic [IDX_W-1:0]          r_gi;
    logic [IDX_W-1:0]          r_bi;
    logic [AW-1:0]             r_g_val;
    logic [AW-1:0]             r_b_val;
    logic [IDX_W:0]            r_g_q;
    logic [IDX_W:0]            r_b_q;
    logic [IDX_W:0]            r_g_rem;
    logic [IDX_W:0]            r_b_rem;
    logic [DCNT_W-1:0]         r_div_cnt;
    logic                      r_taken;
    logic [CW-1:0]             r_g_rd;
    logic [CW-1:0]             r_b_rd;
    logic [CW-1:0]             r_c_rd;
    logic                      r_out_valid;
    tbp_pkg::t_out_item        r_out;

    logic [tbp_pkg::HB_W-1:0]  w_hb;
    logic [HW-1:0]             w_hmask;
    logic [AW-1:0]             w_gval;
    logic [2*AW-1:0]           w_g_prod;
    logic [2*AW-1:0]           w_b_prod;
    logic [IDX_W:0]            w_g_qc;
    logic [IDX_W:0]            w_b_qc;
    logic [IDX_W:0]            w_g_rem;
    logic [IDX_W:0]            w_b_rem;
    logic [IDX_W-1:0]          n_gi;
    logic [IDX_W-1:0]          n_bi;
    logic                      w_gpred;
    logic                      w_bpred;
    logic                      w_agree;
    logic                      w_use_b;
    logic                      w_pred;
    logic                      w_correct;
    logic [CW-1:0]             n_gsh;
    logic [CW-1:0]             n_bim;
    logic [CW-1:0]             n_cho;
    logic [tbp_pkg::CNT_W-1:0] n_correct;
    logic [tbp_pkg::CNT_W-1:0] n_branch;

    // history length above the register width acts as the full width
    always_comb begin
        w_hb = (r_hist_bits > tbp_pkg::HB_W'(HW)) ? tbp_pkg::HB_W'(HW) : r_hist_bits;
        for (int i = 0; i < HW; i++) begin
            w_hmask[i] = (tbp_pkg::HB_W'(i) < w_hb);
        end
        w_gval = i_in_data.branch_address ^ {{(AW-HW){1'b0}}, r_hist & w_hmask};
    end

    // modulo TABLE_ENTRIES: reciprocal quotient estimate (low by at most one),
    // remainder in the low index bits, then one corrective subtract
    always_comb begin
        w_g_prod = {{AW{1'b0}}, r_g_val} * {{AW{1'b0}}, RECIP};
        w_b_prod = {{AW{1'b0}}, r_b_val} * {{AW{1'b0}}, RECIP};
        w_g_qc   = r_g_q * ENT_X;
        w_b_qc   = r_b_q * ENT_X;
        w_g_rem  = r_g_val[IDX_W:0] - w_g_qc;
        w_b_rem  = r_b_val[IDX_W:0] - w_b_qc;
        n_gi = (r_g_rem >= ENT_X) ? IDX_W'(r_g_rem - ENT_X) : IDX_W'(r_g_rem);
        n_bi = (r_b_rem >= ENT_X) ? IDX_W'(r_b_rem - ENT_X) : IDX_W'(r_b_rem);
    end

    always_comb begin
        w_gpred   = r_g_rd[CW-1];
        w_bpred   = r_b_rd[CW-1];
        w_agree   = (w_gpred == w_bpred);
        w_use_b   = !w_agree && r_c_rd[CW-1];
        w_pred    = w_use_b ? w_bpred : w_gpred;
        w_correct = (w_pred == r_taken);
        n_gsh     = tbp_pkg::ctr_step(r_g_rd, r_taken);
        n_bim     = tbp_pkg::ctr_step(r_b_rd, r_taken);
        n_cho     = w_agree ? r_c_rd : tbp_pkg::ctr_step(r_c_rd, w_bpred == r_taken);
        n_branch  = (r_branch == '1) ? r_branch : r_branch + 1'b1;
        n_correct = (w_correct && (r_correct != '1)) ? r_correct + 1'b1 : r_correct;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_we) begin
            gsh_mem[r_clr_idx] <= tbp_pkg::GSH_RESET;
            bim_mem[r_clr_idx] <= tbp_pkg::BIM_RESET;
            cho_mem[r_clr_idx] <= tbp_pkg::CHO_RESET;
        end else if (i_cmd.commit) begin
            gsh_mem[r_gi] <= n_gsh;
            bim_mem[r_bi] <= n_bim;
            cho_mem[r_bi] <= n_cho;
        end
        if (i_cmd.rd_en) begin
            r_g_rd <= gsh_mem[r_gi];
            r_b_rd <= bim_mem[r_bi];
            r_c_rd <= cho_mem[r_bi];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_taken   <= i_in_data.taken;
            r_g_val   <= w_gval;
            r_b_val   <= i_in_data.branch_address;
            r_div_cnt <= '0;
            if (NEED_DIV) begin
                r_gi <= '0;
                r_bi <= '0;
            end else begin
                r_gi <= w_gval[IDX_W-1:0];
                r_bi <= i_in_data.branch_address[IDX_W-1:0];
            end
        end else if (i_cmd.div_step) begin
            r_g_q     <= w_g_prod[AW +: IDX_W+1];
            r_b_q     <= w_b_prod[AW +: IDX_W+1];
            r_g_rem   <= w_g_rem;
            r_b_rem   <= w_b_rem;
            r_gi      <= n_gi;
            r_bi      <= n_bi;
            r_div_cnt <= r_div_cnt + 1'b1;
        end
        if (i_cmd.commit) begin
            r_out.predicted_taken    <= w_pred;
            r_out.prediction_correct <= w_correct;
            r_out.used_bimodal       <= w_use_b;
            r_out.correct_total      <= n_correct;
            r_out.branch_total       <= n_branch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_bits <= tbp_pkg::HB_RESET;
            r_hist      <= '0;
            r_correct   <= '0;
            r_branch    <= '0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_hist_bits <= i_cfg_data;
            end
            if (i_cmd.clr_we) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cmd.commit) begin
                r_hist      <= {r_hist[HW-2:0], r_taken};
                r_correct   <= n_correct;
                r_branch    <= n_branch;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clr_last = (r_clr_idx == IDX_W'(TABLE_ENTRIES - 1));
    assign o_sts.need_div = NEED_DIV;
    assign o_sts.div_last = (r_div_cnt == DCNT_W'(DIV_STEPS - 1));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### sv/tournament_branch_predictor.sv
`timescale 1ns / 1ps
// Tournament branch predictor (gshare and bimodal with a per-address chooser), top level.
// Depends on tbp_pkg, tbp_ctrl and tbp_datapath.
//
// Each request is one resolved conditional branch and yields one result with the
// prediction made before update and saturating running counts. After reset the three
// counter tables are cleared one entry a cycle with o_in_stall high; history_bits
// writes are taken at any time. A branch goes through accept, table read and update
// (through the single read/write port of each table), the update waiting while a
// stalled result is held; when TABLE_ENTRIES is not a power of two a reciprocal-multiply
// modulo reduction of the indices runs between accept and table read. The result
// register lets the next request enter while a result waits on o_out_valid.
module tournament_branch_predictor #(
    parameter int TABLE_ENTRIES = tbp_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  tbp_pkg::t_in_item        i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output tbp_pkg::t_out_item       o_out_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [tbp_pkg::HB_W-1:0] i_cfg_data
);

    tbp_pkg::t_ctl_cmd w_cmd;
    tbp_pkg::t_ctl_sts w_sts;

    tbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tbp_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

### sv/tbp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the tournament branch predictor, bound to the top level.
// Depends on tbp_pkg.
module tbp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input tbp_pkg::t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.correct_total <= o_out_data.branch_total)
        else $error("correct count exceeds branch count");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while previous one in flight");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("not clearing tables after reset");

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

### tb/tb_tournament_branch_predictor.sv
`timescale 1ns / 1ps
// Self-checking testbench for tournament_branch_predictor: random and directed branch streams,
// an in-line predictor of the tables and history, field-by-field result checks.
// Depends on tbp_pkg and the predictor RTL.
module tb_tournament_branch_predictor;
    import tbp_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_ENTRIES_DEF);
    localparam int HOT_PCS = 24;
    localparam int RUN_LEN = 220;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_in_valid  = 1'b0;
    logic            o_in_stall;
    t_in_item        i_in_data   = '0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    t_out_item       o_out_data;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [HB_W-1:0] i_cfg_data  = '0;

    tournament_branch_predictor dut (.*);

    // predictor state
    logic [CTR_W-1:0]  gshare_ctr  [TABLE_ENTRIES_DEF];
    logic [CTR_W-1:0]  bimodal_ctr [TABLE_ENTRIES_DEF];
    logic [CTR_W-1:0]  chooser_ctr [TABLE_ENTRIES_DEF];
    logic [HIST_W-1:0] ghist;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  seen;
    logic [HB_W-1:0]   hist_len;

    t_in_item  pending_branches  [$];
    t_out_item predicted_results [$];
    t_out_item want;

    logic idle_on      = 1'b0;
    int   send_gap     = 0;
    int   stall_gap    = 0;
    int   hold_left    = 0;
    int   holds_done   = 0;
    int   results_seen = 0;
    int   mismatches   = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #500000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void reset_predictor();
        foreach (gshare_ctr[i]) begin
            gshare_ctr[i]  = GSH_RESET;
            bimodal_ctr[i] = BIM_RESET;
            chooser_ctr[i] = CHO_RESET;
        end
        ghist    = '0;
        hits     = '0;
        seen     = '0;
        hist_len = HB_RESET;
    endfunction

    function automatic logic [CTR_W-1:0] nudge(input logic [CTR_W-1:0] c, input logic up);
        if (up && c != CTR_MAX) begin
            return c + 1'b1;
        end
        if (!up && c != CTR_MIN) begin
            return c - 1'b1;
        end
        return c;
    endfunction

    function automatic t_out_item resolve_branch(input t_in_item br);
        int unsigned      len;
        logic [31:0]      hmask;
        logic [31:0]      gsum;
        logic [IDX_W-1:0] gi;
        logic [IDX_W-1:0] bi;
        logic             gp;
        logic             bp;
        t_out_item        r;
        // lengths beyond the register width saturate at the full history
        len   = (hist_len > HIST_W) ? HIST_W : hist_len;
        hmask = (32'd1 << len) - 32'd1;
        gsum  = br.branch_address ^ (32'(ghist) & hmask);
        gi    = gsum[IDX_W-1:0];
        bi    = br.branch_address[IDX_W-1:0];
        gp    = gshare_ctr[gi][1];
        bp    = bimodal_ctr[bi][1];
        r     = '0;
        if (gp == bp) begin
            r.predicted_taken = gp;
        end else begin
            r.used_bimodal    = chooser_ctr[bi][1];
            r.predicted_taken = r.used_bimodal ? bp : gp;
            chooser_ctr[bi]   = nudge(chooser_ctr[bi], bp == br.taken);
        end
        r.prediction_correct = (r.predicted_taken == br.taken);
        gshare_ctr[gi]  = nudge(gshare_ctr[gi], br.taken);
        bimodal_ctr[bi] = nudge(bimodal_ctr[bi], br.taken);
        ghist = {ghist[HIST_W-2:0], br.taken};
        if (seen != '1) begin
            seen++;
        end
        if (r.prediction_correct && hits != '1) begin
            hits++;
        end
        r.correct_total = hits;
        r.branch_total  = seen;
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want_v, got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want_v, got_v);
            mismatches++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predicted_results.push_back(resolve_branch(i_in_data));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_branches.size() > 0) begin
                    i_in_data  <= pending_branches.pop_front();
                    i_in_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0) begin
                        send_gap = $urandom_range(1, 4);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (predicted_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %p", $time, o_out_data);
                    mismatches++;
                end else begin
                    want = predicted_results.pop_front();
                    compare_field("predicted_taken", 32'(want.predicted_taken),
                                  32'(o_out_data.predicted_taken));
                    compare_field("prediction_correct", 32'(want.prediction_correct),
                                  32'(o_out_data.prediction_correct));
                    compare_field("used_bimodal", 32'(want.used_bimodal),
                                  32'(o_out_data.used_bimodal));
                    compare_field("correct_total", want.correct_total, o_out_data.correct_total);
                    compare_field("branch_total", want.branch_total, o_out_data.branch_total);
                end
            end
            // long hold-offs to back the block up into its input
            if (hold_left == 0 && holds_done < 2 && results_seen >= (holds_done + 1) * 400) begin
                hold_left = 150;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_gap > 0) begin
                stall_gap--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_gap = $urandom_range(0, 3);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic void push_branch(input logic [ADDR_W-1:0] pc, input logic tk);
        pending_branches.push_back(t_in_item'{pc, tk});
    endfunction

    task automatic queue_branch_run(input int n);
        logic [ADDR_W-1:0] hot [HOT_PCS];
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        int                target;
        int                kind;
        int                trips;
        logic              bias;
        logic              x;
        foreach (hot[i]) begin
            hot[i] = $urandom();
            // some branches alias in the tables
            if (i > 0 && $urandom_range(0, 3) == 0) begin
                hot[i][IDX_W-1:0] = hot[i-1][IDX_W-1:0];
            end
        end
        target = pending_branches.size() + n;
        while (pending_branches.size() < target) begin
            kind = $urandom_range(0, 9);
            a    = hot[$urandom_range(0, HOT_PCS - 1)];
            if (kind < 3) begin
                // loop branch
                trips = $urandom_range(2, 8);
                repeat ($urandom_range(1, 4)) begin
                    repeat (trips - 1) begin
                        push_branch(a, 1'b1);
                    end
                    push_branch(a, 1'b0);
                end
            end else if (kind < 6) begin
                // correlated pair, learnable only through history
                b = hot[$urandom_range(0, HOT_PCS - 1)];
                repeat ($urandom_range(4, 12)) begin
                    x = 1'($urandom_range(0, 1));
                    push_branch(a, x);
                    push_branch(b, x);
                end
            end else if (kind < 8) begin
                bias = 1'($urandom_range(0, 1));
                repeat ($urandom_range(8, 16)) begin
                    push_branch(a, ($urandom_range(0, 7) == 0) ? !bias : bias);
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    push_branch($urandom(), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_branches.size() != 0 || i_in_valid || predicted_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_history_len(input logic [HB_W-1:0] len);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        hist_len = len;
    endtask

    initial begin
        logic [HB_W-1:0] hist_settings [8];
        hist_settings = '{4'd0, 4'd15, 4'd12, 4'd1, 4'd6, 4'd11, 4'd3, 4'd9};
        hist_settings[4] = HB_W'($urandom_range(2, 10));
        reset_predictor();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        idle_on = 1'b1;
        push_branch(32'h0000_0000, 1'b1);
        push_branch(32'hFFFF_FFFF, 1'b0);
        push_branch(32'h8000_0000, 1'b1);
        push_branch(32'h7FFF_FFFF, 1'b0);
        push_branch(32'h0000_07FF, 1'b0);
        push_branch(32'h0000_0800, 1'b0);
        // drive one bimodal entry down so the two predictors disagree
        repeat (4) begin
            push_branch(32'h0000_1234, 1'b0);
        end
        push_branch(32'h0000_1234, 1'b1);
        push_branch(32'h0000_1234, 1'b1);
        push_branch(32'hAAAA_AAAA, 1'b1);
        push_branch(32'h5555_5555, 1'b0);
        push_branch(32'h0000_1234, 1'b0);
        push_branch(32'h0000_1234, 1'b0);
        push_branch(32'hFFFF_F800, 1'b1);
        push_branch(32'h0000_1234, 1'b1);
        wait_drained();
        foreach (hist_settings[p]) begin
            write_history_len(hist_settings[p]);
            @(negedge i_clk);
            idle_on = (p != $size(hist_settings) - 1);
            queue_branch_run(RUN_LEN);
            wait_drained();
        end
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && predicted_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
